[hdl/ccse_pkg.sv]
// Shared types and constants for the cumulative count slope estimator.
package ccse_pkg;

   localparam int SAMPLE_W   = 16;
   localparam int BASE_W     = 16;
   localparam int STEP_W     = 12;
   localparam int SCALE_W    = 10;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 16;
   localparam int T_W        = 18;
   localparam int N_W        = 6;
   localparam int Y_W        = 16;
   localparam int E_W        = 5;
   localparam int M_W        = 16;
   localparam int FRAC_W     = 16;
   localparam int L2_W       = E_W + FRAC_W;
   localparam int B_W        = 24;
   localparam int ST_W       = T_W + N_W;
   localparam int STT_W      = 2 * T_W + N_W;
   localparam int SY_W       = Y_W + N_W;
   localparam int STY_W      = T_W + Y_W + N_W;
   localparam int NUM_W      = 49;
   localparam int DIV_W      = 64;

   localparam logic [14:0] LOG10_2_Q16 = 15'd19728;

   localparam logic [CSR_IDX_W-1:0] CSR_BASE  = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_STEP  = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_SCALE = 2'd2;

   localparam logic [BASE_W-1:0]  BASE_RESET  = 16'd28;
   localparam logic [STEP_W-1:0]  STEP_RESET  = 12'd2;
   localparam logic [SCALE_W-1:0] SCALE_RESET = 10'd20;

   localparam logic signed [B_W-1:0] B_MAX = 24'sh7FFFFF;
   localparam logic signed [B_W-1:0] B_MIN = 24'sh800000;

   typedef struct packed {
      logic                inc;
      logic                shift;
      logic [SAMPLE_W-1:0] sample;
   } cell_ctl_type;

   typedef struct packed {
      logic [BASE_W-1:0]  base;
      logic [STEP_W-1:0]  step;
      logic [SCALE_W-1:0] scale;
   } cfg_type;

endpackage

[hdl/cumulative_count_slope_estimator_top.sv]
// Top level: config registers, bin cell chain and fit engine.
// Samples are taken one per cycle while busy is low. The final sample starts the fit:
// per nonzero bin a load, 16 log squarings in one shared multiplier, a y step and an
// accumulate, per empty bin a load only; then products and scaling, a divide for a
// usable fit only and saturation; rsp_valid strobes one cycle, unstallable, as busy drops.
// Synchronous reset clears all bin counts and loads the default thresholds and scale.
module cumulative_count_slope_estimator_top #(
   parameter int NUM_BINS   = 13,
   parameter int COUNT_BITS = 20
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   start,
   output logic                                   busy,
   input  logic [ccse_pkg::SAMPLE_W-1:0]          req_sample,
   input  logic                                   req_last,
   output logic                                   rsp_valid,
   output logic signed [ccse_pkg::B_W-1:0]        rsp_b_value,
   output logic                                   rsp_fit_ok,
   output logic [ccse_pkg::N_W-1:0]               rsp_bins_used,
   input  logic                                   csr_we,
   input  logic [ccse_pkg::CSR_IDX_W-1:0]         csr_index,
   input  logic [ccse_pkg::CSR_DATA_W-1:0]        csr_wdata
);

   ccse_pkg::cfg_type      cfg_ff, cfg_in;
   ccse_pkg::cell_ctl_type ctl;
   logic                   accept;
   logic                   shift;
   logic [COUNT_BITS-1:0]  counts [NUM_BINS+1];

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         case (csr_index)
            ccse_pkg::CSR_BASE:  cfg_in.base  = csr_wdata[ccse_pkg::BASE_W-1:0];
            ccse_pkg::CSR_STEP:  cfg_in.step  = csr_wdata[ccse_pkg::STEP_W-1:0];
            ccse_pkg::CSR_SCALE: cfg_in.scale = csr_wdata[ccse_pkg::SCALE_W-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.base  <= ccse_pkg::BASE_RESET;
         cfg_ff.step  <= ccse_pkg::STEP_RESET;
         cfg_ff.scale <= ccse_pkg::SCALE_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign accept     = start && !busy;
   assign ctl.inc    = accept;
   assign ctl.shift  = shift;
   assign ctl.sample = req_sample;
   assign counts[NUM_BINS] = '0;

   for (genvar j = 0; j < NUM_BINS; j++) begin : g_cell
      ccse_cell #(.IDX(j), .COUNT_BITS(COUNT_BITS)) u_cell (
         .clock    (clock),
         .reset    (reset),
         .ctl      (ctl),
         .cfg      (cfg_ff),
         .count_nb (counts[j+1]),
         .count    (counts[j])
      );
   end

   ccse_fit #(.NUM_BINS(NUM_BINS), .COUNT_BITS(COUNT_BITS)) u_fit (
      .clock         (clock),
      .reset         (reset),
      .go            (accept && req_last),
      .cfg           (cfg_ff),
      .head_count    (counts[0]),
      .shift         (shift),
      .busy          (busy),
      .rsp_valid     (rsp_valid),
      .rsp_b_value   (rsp_b_value),
      .rsp_fit_ok    (rsp_fit_ok),
      .rsp_bins_used (rsp_bins_used)
   );

endmodule

[hdl/ccse_cell.sv]
// One bin cell: counts samples above its threshold and shifts its count toward the head.
module ccse_cell #(
   parameter int IDX        = 0,
   parameter int COUNT_BITS = 20
) (
   input  logic                         clock,
   input  logic                         reset,
   input  ccse_pkg::cell_ctl_type       ctl,
   input  ccse_pkg::cfg_type            cfg,
   input  logic [COUNT_BITS-1:0]        count_nb,
   output logic [COUNT_BITS-1:0]        count
);

   logic [COUNT_BITS-1:0]   count_ff;
   logic [COUNT_BITS-1:0]   count_in;
   logic [ccse_pkg::T_W-1:0] thr;
   logic                    above;

   assign thr   = ccse_pkg::T_W'(cfg.base) + ccse_pkg::T_W'(int'(cfg.step) * IDX);
   assign above = ccse_pkg::T_W'(ctl.sample) > thr;

   always_comb begin
      count_in = count_ff;
      if (ctl.shift) begin
         count_in = count_nb;
      end else if (ctl.inc && above && !(&count_ff)) begin
         count_in = count_ff + COUNT_BITS'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
      end
   end

   assign count = count_ff;

endmodule

[hdl/ccse_fit.sv]
// Least-squares fit engine: pulls bin counts from the cell chain, takes log10, fits and divides.
module ccse_fit #(
   parameter int NUM_BINS   = 13,
   parameter int COUNT_BITS = 20
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                go,
   input  ccse_pkg::cfg_type                   cfg,
   input  logic [COUNT_BITS-1:0]               head_count,
   output logic                                shift,
   output logic                                busy,
   output logic                                rsp_valid,
   output logic signed [ccse_pkg::B_W-1:0]     rsp_b_value,
   output logic                                rsp_fit_ok,
   output logic [ccse_pkg::N_W-1:0]            rsp_bins_used
);

   localparam int BC_W = $clog2(NUM_BINS);
   localparam int NUM_W = ccse_pkg::NUM_W;
   localparam int DIV_W = ccse_pkg::DIV_W;

   localparam logic [3:0] S_IDLE  = 4'd0;
   localparam logic [3:0] S_LOAD  = 4'd1;
   localparam logic [3:0] S_LOG   = 4'd2;
   localparam logic [3:0] S_YCALC = 4'd3;
   localparam logic [3:0] S_ACC   = 4'd4;
   localparam logic [3:0] S_FIN1  = 4'd5;
   localparam logic [3:0] S_FIN2  = 4'd6;
   localparam logic [3:0] S_FIN3  = 4'd7;
   localparam logic [3:0] S_FIN4  = 4'd8;
   localparam logic [3:0] S_DIV   = 4'd9;
   localparam logic [3:0] S_DONE  = 4'd10;

   logic [3:0] state_ff, state_in;
   logic [BC_W-1:0] bin_ff, bin_in;
   logic [ccse_pkg::T_W-1:0] t_ff, t_in;
   logic [ccse_pkg::E_W-1:0] e_ff, e_in;
   logic [ccse_pkg::M_W-1:0] m_ff, m_in;
   logic [ccse_pkg::FRAC_W-1:0] frac_ff, frac_in;
   logic [3:0] it_ff, it_in;
   logic [ccse_pkg::Y_W-1:0] y_ff, y_in;
   logic [ccse_pkg::N_W-1:0] n_ff, n_in;
   logic [ccse_pkg::ST_W-1:0] st_ff, st_in;
   logic [ccse_pkg::STT_W-1:0] stt_ff, stt_in;
   logic [ccse_pkg::SY_W-1:0] sy_ff, sy_in;
   logic [ccse_pkg::STY_W-1:0] sty_ff, sty_in;
   logic [NUM_W-1:0] pa_ff, pa_in, pb_ff, pb_in, pc_ff, pc_in, pd_ff, pd_in;
   logic signed [NUM_W-1:0] num_ff, num_in;
   logic [NUM_W-1:0] den_ff, den_in;
   logic ok_ff, ok_in;
   logic pos_ff, pos_in;
   logic [DIV_W-1:0] mag_ff, mag_in;
   logic [DIV_W-1:0] dq_ff, dq_in;
   logic [NUM_W-1:0] rem_ff, rem_in;
   logic [5:0] dcnt_ff, dcnt_in;
   logic valid_ff, valid_in;
   logic signed [ccse_pkg::B_W-1:0] b_ff, b_in;
   logic fok_ff, fok_in;
   logic [ccse_pkg::N_W-1:0] used_ff, used_in;

   logic [31:0] cw;
   logic [ccse_pkg::E_W-1:0] lead;
   logic [31:0] norm;
   logic [31:0] sq;
   logic [16:0] sq_sh;
   logic [36:0] yprod;
   logic [NUM_W-1:0] num_abs;
   logic [NUM_W:0] rem_sh;
   logic last_bin;

   assign cw = 32'(head_count);

   always_comb begin
      lead = '0;
      for (int i = 0; i < COUNT_BITS; i++) begin
         if (cw[i]) lead = ccse_pkg::E_W'(i);
      end
   end

   assign norm  = (lead >= ccse_pkg::E_W'(15)) ? (cw >> (lead - ccse_pkg::E_W'(15)))
                                               : (cw << (ccse_pkg::E_W'(15) - lead));
   assign sq    = 32'(m_ff) * 32'(m_ff);
   assign sq_sh = sq[31:15];
   assign yprod = 37'({e_ff, frac_ff}) * 37'(ccse_pkg::LOG10_2_Q16) + 37'(1 << 19);
   assign num_abs = num_ff[NUM_W-1] ? NUM_W'(-num_ff) : NUM_W'(num_ff);
   assign rem_sh  = {rem_ff, dq_ff[DIV_W-1]};
   assign last_bin = (bin_ff == BC_W'(NUM_BINS - 1));

   always_comb begin
      state_in = state_ff; bin_in = bin_ff; t_in = t_ff; e_in = e_ff; m_in = m_ff;
      frac_in = frac_ff; it_in = it_ff; y_in = y_ff; n_in = n_ff; st_in = st_ff;
      stt_in = stt_ff; sy_in = sy_ff; sty_in = sty_ff; pa_in = pa_ff; pb_in = pb_ff;
      pc_in = pc_ff; pd_in = pd_ff; num_in = num_ff; den_in = den_ff; ok_in = ok_ff;
      pos_in = pos_ff; mag_in = mag_ff; dq_in = dq_ff; rem_in = rem_ff; dcnt_in = dcnt_ff;
      valid_in = 1'b0; b_in = b_ff; fok_in = fok_ff; used_in = used_ff;
      case (state_ff)
         S_IDLE: begin
            if (go) begin
               state_in = S_LOAD;
               bin_in = '0; t_in = ccse_pkg::T_W'(cfg.base);
               n_in = '0; st_in = '0; stt_in = '0; sy_in = '0; sty_in = '0;
            end
         end
         S_LOAD: begin
            if (head_count == '0) begin
               bin_in = bin_ff + BC_W'(1);
               t_in = t_ff + ccse_pkg::T_W'(cfg.step);
               state_in = last_bin ? S_FIN1 : S_LOAD;
            end else begin
               e_in = lead; m_in = norm[ccse_pkg::M_W-1:0]; frac_in = '0; it_in = '0;
               state_in = S_LOG;
            end
         end
         S_LOG: begin
            // square the mantissa; overflow past 2.0 yields the next fraction bit
            frac_in = {frac_ff[ccse_pkg::FRAC_W-2:0], sq_sh[16]};
            m_in = sq_sh[16] ? sq_sh[16:1] : sq_sh[15:0];
            it_in = it_ff + 4'd1;
            if (it_ff == 4'd15) state_in = S_YCALC;
         end
         S_YCALC: begin
            y_in = yprod[35:20];
            state_in = S_ACC;
         end
         S_ACC: begin
            n_in = n_ff + ccse_pkg::N_W'(1);
            st_in = st_ff + ccse_pkg::ST_W'(t_ff);
            stt_in = stt_ff + ccse_pkg::STT_W'(t_ff) * ccse_pkg::STT_W'(t_ff);
            sy_in = sy_ff + ccse_pkg::SY_W'(y_ff);
            sty_in = sty_ff + ccse_pkg::STY_W'(t_ff) * ccse_pkg::STY_W'(y_ff);
            bin_in = bin_ff + BC_W'(1);
            t_in = t_ff + ccse_pkg::T_W'(cfg.step);
            state_in = last_bin ? S_FIN1 : S_LOAD;
         end
         S_FIN1: begin
            pa_in = NUM_W'(n_ff) * NUM_W'(sty_ff);
            pb_in = NUM_W'(st_ff) * NUM_W'(sy_ff);
            pc_in = NUM_W'(n_ff) * NUM_W'(stt_ff);
            pd_in = NUM_W'(st_ff) * NUM_W'(st_ff);
            state_in = S_FIN2;
         end
         S_FIN2: begin
            num_in = signed'(pa_ff - pb_ff);
            den_in = pc_ff - pd_ff;
            state_in = S_FIN3;
         end
         S_FIN3: begin
            ok_in = (n_ff >= ccse_pkg::N_W'(2)) && (den_ff != '0) && (cfg.scale != '0);
            pos_in = !num_ff[NUM_W-1] && (num_ff != '0);
            mag_in = (DIV_W'(num_abs) * DIV_W'(cfg.scale)) << 4;
            state_in = S_FIN4;
         end
         S_FIN4: begin
            dq_in = mag_ff + DIV_W'(den_ff >> 1);
            rem_in = '0; dcnt_in = '0;
            state_in = ok_ff ? S_DIV : S_DONE;
         end
         S_DIV: begin
            if (rem_sh >= {1'b0, den_ff}) begin
               rem_in = NUM_W'(rem_sh - {1'b0, den_ff});
               dq_in = {dq_ff[DIV_W-2:0], 1'b1};
            end else begin
               rem_in = rem_sh[NUM_W-1:0];
               dq_in = {dq_ff[DIV_W-2:0], 1'b0};
            end
            dcnt_in = dcnt_ff + 6'd1;
            if (dcnt_ff == 6'd63) state_in = S_DONE;
         end
         S_DONE: begin
            if (!ok_ff) begin
               b_in = '0;
            end else if (pos_ff) begin
               b_in = (dq_ff > DIV_W'(1 << 23)) ? ccse_pkg::B_MIN
                                                : ccse_pkg::B_W'(-dq_ff[ccse_pkg::B_W-1:0]);
            end else begin
               b_in = (dq_ff > DIV_W'(ccse_pkg::B_MAX)) ? ccse_pkg::B_MAX
                                                        : signed'(dq_ff[ccse_pkg::B_W-1:0]);
            end
            fok_in = ok_ff; used_in = n_ff; valid_in = 1'b1;
            state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      bin_ff <= bin_in; t_ff <= t_in; e_ff <= e_in; m_ff <= m_in; frac_ff <= frac_in;
      it_ff <= it_in; y_ff <= y_in; n_ff <= n_in; st_ff <= st_in; stt_ff <= stt_in;
      sy_ff <= sy_in; sty_ff <= sty_in; pa_ff <= pa_in; pb_ff <= pb_in; pc_ff <= pc_in;
      pd_ff <= pd_in; num_ff <= num_in; den_ff <= den_in; ok_ff <= ok_in; pos_ff <= pos_in;
      mag_ff <= mag_in; dq_ff <= dq_in; rem_ff <= rem_in; dcnt_ff <= dcnt_in;
      b_ff <= b_in; fok_ff <= fok_in; used_ff <= used_in;
   end

   // drain one cell per visit to the head; zeros enter at the tail
   assign shift         = (state_ff == S_LOAD);
   assign busy          = (state_ff != S_IDLE);
   assign rsp_valid     = valid_ff;
   assign rsp_b_value   = b_ff;
   assign rsp_fit_ok    = fok_ff;
   assign rsp_bins_used = used_ff;

endmodule
